/* rtl/core/rfcaf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rfcaf_pkg;

  // Frame geometry
  localparam int MAX_PAYLOAD = 32;
  localparam int PAY_AW      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int BYTE_W      = 8;
  localparam int CNT_W       = 6;
  localparam int IDX_W       = 6;
  localparam int VERD_W      = 3;
  localparam int CFG_IDX_W   = 3;

  // Delimiters and group address fields
  localparam logic [BYTE_W-1:0] CH_START = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_END   = 8'h23;
  localparam logic [BYTE_W-1:0] PFX_MASK = 8'hC0;
  localparam logic [BYTE_W-1:0] PFX_VAL  = 8'h80;
  localparam logic [BYTE_W-1:0] GID_MASK = 8'h3F;

  // Register reset values
  localparam logic [BYTE_W-1:0] OWN_ID_RST    = 8'd1;
  localparam logic [BYTE_W-1:0] BCAST_ID_RST  = 8'd255;
  localparam logic [BYTE_W-1:0] VESTS_ID_RST  = 8'd253;
  localparam logic [BYTE_W-1:0] EVEN_GRP_RST  = 8'd254;
  localparam logic [BYTE_W-1:0] ODD_GRP_RST   = 8'd252;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ID,
    CFG_BROADCAST_ID,
    CFG_ALL_VESTS_ID,
    CFG_EVEN_GROUP_ID,
    CFG_ODD_GROUP_ID
  } cfg_reg_t;

  typedef enum logic [VERD_W-1:0] {
    V_ACCEPT,
    V_BAD_START,
    V_BAD_END,
    V_BAD_SUM,
    V_ADDR_MISS,
    V_TOO_LONG
  } verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEST,
    ST_SRC,
    ST_LEN,
    ST_PAY,
    ST_SUM,
    ST_END,
    ST_EMIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic     frame_clr;
    logic     cap_dest;
    logic     cap_src;
    logic     cap_len;
    logic     cap_pay;
    logic     cap_sum;
    logic     put_verdict;
    verdict_t verdict;
    logic     emit_clr;
    logic     emit_put;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_start;
    logic is_end;
    logic len_big;
    logic len_zero;
    logic pay_done;
    logic sum_bad;
    logic addr_ok;
    logic emit_last;
    logic slot_free;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/core/rfcaf_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface rfcaf_in_if;
  logic                           valid;
  logic                           ready;
  logic [rfcaf_pkg::BYTE_W-1:0]   rx_byte;
  logic                           frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

`default_nettype wire

/* rtl/core/rfcaf_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface rfcaf_out_if;
  logic                           valid;
  logic                           ready;
  logic [rfcaf_pkg::BYTE_W-1:0]   out_byte;
  logic [rfcaf_pkg::IDX_W-1:0]    out_index;
  logic [rfcaf_pkg::VERD_W-1:0]   verdict;
  logic                           last;

  modport source (output valid, output out_byte, output out_index, output verdict,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input out_index, input verdict,
                  input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/radio_frame_checker_address_filter.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake       Payload
// in_ch     in   valid / ready   rx_byte[7:0], frame_start
// out_ch    out  valid / ready   out_byte[7:0], out_index[5:0], verdict[2:0], last
// cfg       in   cfg_we          cfg_index[2:0], cfg_data[7:0]
//
// One received byte per cycle is taken in a frame while the output slot is free.
// An accepted frame sends 3 + length results after its trailer, one per cycle
// while the slot is free; the burst sequencer holds the input off until the last.
// A rejection sends one result through the same output register.
// Input stalls while that output register is full and not being taken.
// Reset is synchronous; the payload store needs no clearing.

module radio_frame_checker_address_filter (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  rfcaf_in_if.sink                               in_ch,
  rfcaf_out_if.source                            out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [rfcaf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rfcaf_pkg::BYTE_W-1:0]      cfg_data
);

  rfcaf_pkg::cmd_t  cmd;
  rfcaf_pkg::stat_t stat;
  logic             in_ready;
  logic             out_valid;
  logic [rfcaf_pkg::BYTE_W-1:0] out_byte;
  logic [rfcaf_pkg::IDX_W-1:0]  out_index;
  logic [rfcaf_pkg::VERD_W-1:0] out_verdict;
  logic             out_last;

  // Sequence each request
  rfcaf_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_frame_start (in_ch.frame_start),
    .in_ready       (in_ready),
    .stat           (stat),
    .cmd            (cmd)
  );

  // Hold frame state, filter, and drive results
  rfcaf_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_rx_byte  (in_ch.rx_byte),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (out_ch.ready),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .out_index   (out_index),
    .out_verdict (out_verdict),
    .out_last    (out_last)
  );

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid;
  assign out_ch.out_byte  = out_byte;
  assign out_ch.out_index = out_index;
  assign out_ch.verdict   = out_verdict;
  assign out_ch.last      = out_last;

endmodule

`default_nettype wire

/* rtl/core/rfcaf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module rfcaf_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_frame_start,
  output logic                  in_ready,
  input  wire rfcaf_pkg::stat_t stat,
  output rfcaf_pkg::cmd_t       cmd
);

  rfcaf_pkg::state_t state_r, state_nxt;
  logic              fire;

  // Take a request only when the output slot can hold a result
  assign in_ready = (state_r != rfcaf_pkg::ST_EMIT) && stat.slot_free;
  assign fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rfcaf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    if (state_r == rfcaf_pkg::ST_EMIT) begin
      if (stat.slot_free && stat.emit_last) begin
        state_nxt = rfcaf_pkg::ST_IDLE;
      end
    end else if (fire) begin
      if (in_frame_start) begin
        state_nxt = stat.is_start ? rfcaf_pkg::ST_DEST : rfcaf_pkg::ST_IDLE;
      end else begin
        unique case (state_r)
          rfcaf_pkg::ST_IDLE: state_nxt = rfcaf_pkg::ST_IDLE;
          rfcaf_pkg::ST_DEST: state_nxt = rfcaf_pkg::ST_SRC;
          rfcaf_pkg::ST_SRC:  state_nxt = rfcaf_pkg::ST_LEN;
          rfcaf_pkg::ST_LEN: begin
            if (stat.len_big) begin
              state_nxt = rfcaf_pkg::ST_IDLE;
            end else begin
              state_nxt = stat.len_zero ? rfcaf_pkg::ST_SUM : rfcaf_pkg::ST_PAY;
            end
          end
          rfcaf_pkg::ST_PAY: begin
            if (stat.pay_done) begin
              state_nxt = rfcaf_pkg::ST_SUM;
            end
          end
          rfcaf_pkg::ST_SUM:  state_nxt = rfcaf_pkg::ST_END;
          rfcaf_pkg::ST_END: begin
            if (stat.is_end && !stat.sum_bad && stat.addr_ok) begin
              state_nxt = rfcaf_pkg::ST_EMIT;
            end else begin
              state_nxt = rfcaf_pkg::ST_IDLE;
            end
          end
          default: state_nxt = rfcaf_pkg::ST_IDLE;
        endcase
      end
    end
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    cmd.verdict = rfcaf_pkg::V_ACCEPT;
    if (state_r == rfcaf_pkg::ST_EMIT) begin
      cmd.emit_put = stat.slot_free;
    end else if (fire) begin
      if (in_frame_start) begin
        cmd.frame_clr = 1'b1;
        if (!stat.is_start) begin
          cmd.put_verdict = 1'b1;
          cmd.verdict     = rfcaf_pkg::V_BAD_START;
        end
      end else begin
        unique case (state_r)
          rfcaf_pkg::ST_IDLE: cmd.frame_clr = 1'b0;
          rfcaf_pkg::ST_DEST: cmd.cap_dest  = 1'b1;
          rfcaf_pkg::ST_SRC:  cmd.cap_src   = 1'b1;
          rfcaf_pkg::ST_LEN: begin
            if (stat.len_big) begin
              cmd.put_verdict = 1'b1;
              cmd.verdict     = rfcaf_pkg::V_TOO_LONG;
            end else begin
              cmd.cap_len = 1'b1;
            end
          end
          rfcaf_pkg::ST_PAY:  cmd.cap_pay = 1'b1;
          rfcaf_pkg::ST_SUM:  cmd.cap_sum = 1'b1;
          rfcaf_pkg::ST_END: begin
            // Judge the trailer, then the sum, then the address
            priority if (!stat.is_end) begin
              cmd.put_verdict = 1'b1;
              cmd.verdict     = rfcaf_pkg::V_BAD_END;
            end else if (stat.sum_bad) begin
              cmd.put_verdict = 1'b1;
              cmd.verdict     = rfcaf_pkg::V_BAD_SUM;
            end else if (!stat.addr_ok) begin
              cmd.put_verdict = 1'b1;
              cmd.verdict     = rfcaf_pkg::V_ADDR_MISS;
            end else begin
              cmd.emit_clr = 1'b1;
            end
          end
          default: cmd.frame_clr = 1'b0;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rfcaf_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module rfcaf_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [rfcaf_pkg::BYTE_W-1:0]         in_rx_byte,
  input  wire logic                                 cfg_we,
  input  wire logic [rfcaf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rfcaf_pkg::BYTE_W-1:0]         cfg_data,
  input  wire rfcaf_pkg::cmd_t                      cmd,
  output rfcaf_pkg::stat_t                          stat,
  input  wire logic                                 out_ready,
  output logic                                      out_valid,
  output logic [rfcaf_pkg::BYTE_W-1:0]              out_byte,
  output logic [rfcaf_pkg::IDX_W-1:0]               out_index,
  output logic [rfcaf_pkg::VERD_W-1:0]              out_verdict,
  output logic                                      out_last
);

  localparam int BW = rfcaf_pkg::BYTE_W;
  localparam int CW = rfcaf_pkg::CNT_W;
  localparam int AW = rfcaf_pkg::PAY_AW;
  localparam int IW = rfcaf_pkg::IDX_W;

  // Address filter registers
  logic [BW-1:0] own_id_r, bcast_id_r, vests_id_r, even_grp_r, odd_grp_r;

  // Frame state
  logic [CW-1:0] byte_count_r;
  logic [CW-1:0] frame_len_r;
  logic [BW-1:0] run_sum_r;
  logic [BW-1:0] dest_r;
  logic [BW-1:0] src_r;
  logic          sum_bad_r;

  // Result burst state
  logic [IW-1:0] emit_k_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] rd_addr;
  logic [BW-1:0] rd_data_r;
  logic [BW-1:0] pay_mem [rfcaf_pkg::MAX_PAYLOAD];

  // Output register
  logic          out_valid_r;
  logic [BW-1:0] out_byte_r;
  logic [IW-1:0] out_index_r;
  logic [rfcaf_pkg::VERD_W-1:0] out_verdict_r;
  logic          out_last_r;

  logic [BW-1:0] game_id;
  logic          pfx_hit;
  logic          emit_pay;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r   <= rfcaf_pkg::OWN_ID_RST;
      bcast_id_r <= rfcaf_pkg::BCAST_ID_RST;
      vests_id_r <= rfcaf_pkg::VESTS_ID_RST;
      even_grp_r <= rfcaf_pkg::EVEN_GRP_RST;
      odd_grp_r  <= rfcaf_pkg::ODD_GRP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rfcaf_pkg::CFG_OWN_ID:        own_id_r   <= cfg_data;
        rfcaf_pkg::CFG_BROADCAST_ID:  bcast_id_r <= cfg_data;
        rfcaf_pkg::CFG_ALL_VESTS_ID:  vests_id_r <= cfg_data;
        rfcaf_pkg::CFG_EVEN_GROUP_ID: even_grp_r <= cfg_data;
        rfcaf_pkg::CFG_ODD_GROUP_ID:  odd_grp_r  <= cfg_data;
        default:                      own_id_r   <= own_id_r;
      endcase
    end
  end

  // Capture header, count payload, accumulate sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      frame_len_r  <= '0;
      run_sum_r    <= '0;
      dest_r       <= '0;
      src_r        <= '0;
      sum_bad_r    <= 1'b0;
    end else begin
      if (cmd.frame_clr) begin
        byte_count_r <= '0;
        frame_len_r  <= '0;
        run_sum_r    <= '0;
        sum_bad_r    <= 1'b0;
      end
      if (cmd.cap_dest) begin
        dest_r <= in_rx_byte;
      end
      if (cmd.cap_src) begin
        src_r <= in_rx_byte;
      end
      if (cmd.cap_len) begin
        frame_len_r  <= in_rx_byte[CW-1:0];
        byte_count_r <= '0;
      end
      if (cmd.cap_pay) begin
        run_sum_r    <= run_sum_r + in_rx_byte;
        byte_count_r <= byte_count_r + CW'(1);
      end
      if (cmd.cap_sum) begin
        sum_bad_r <= (in_rx_byte != run_sum_r);
      end
    end
  end

  // Payload store write
  always_ff @(posedge clk) begin
    if (cmd.cap_pay) begin
      pay_mem[byte_count_r[AW-1:0]] <= in_rx_byte;
    end
  end

  // Read one payload entry ahead of the burst
  assign emit_pay = cmd.emit_put && (emit_k_r >= IW'(3));
  assign rd_addr  = emit_pay ? (rd_ptr_r + AW'(1)) : rd_ptr_r;

  always_ff @(posedge clk) begin
    rd_data_r <= pay_mem[rd_addr];
  end

  // Burst position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_k_r <= '0;
      rd_ptr_r <= '0;
    end else if (cmd.emit_clr) begin
      emit_k_r <= '0;
      rd_ptr_r <= '0;
    end else if (cmd.emit_put) begin
      emit_k_r <= emit_k_r + IW'(1);
      rd_ptr_r <= rd_addr;
    end
  end

  // Address filter
  assign game_id = {1'b0, own_id_r[BW-1:1]} + BW'(1);
  assign pfx_hit = ((dest_r & rfcaf_pkg::PFX_MASK) == rfcaf_pkg::PFX_VAL) &&
                   ((dest_r & rfcaf_pkg::GID_MASK) == game_id);

  always_comb begin
    stat.is_start  = (in_rx_byte == rfcaf_pkg::CH_START);
    stat.is_end    = (in_rx_byte == rfcaf_pkg::CH_END);
    stat.len_big   = (in_rx_byte > BW'(rfcaf_pkg::MAX_PAYLOAD));
    stat.len_zero  = (in_rx_byte == '0);
    stat.pay_done  = ((7'(byte_count_r) + 7'd1) >= 7'(frame_len_r));
    stat.sum_bad   = sum_bad_r;
    stat.addr_ok   = (dest_r == own_id_r) || (dest_r == bcast_id_r) ||
                     (dest_r == vests_id_r) ||
                     ((dest_r == even_grp_r) && !game_id[0]) ||
                     ((dest_r == odd_grp_r) && game_id[0]) || pfx_hit;
    stat.emit_last = (7'(emit_k_r) == (7'(frame_len_r) + 7'd2));
    stat.slot_free = !out_valid_r || out_ready;
  end

  // Output register: load a verdict or the next forwarded byte, drop on take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.put_verdict || cmd.emit_put) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_verdict) begin
      out_byte_r    <= '0;
      out_index_r   <= '0;
      out_verdict_r <= cmd.verdict;
      out_last_r    <= 1'b1;
    end else if (cmd.emit_put) begin
      priority if (emit_k_r == IW'(0)) begin
        out_byte_r <= dest_r;
      end else if (emit_k_r == IW'(1)) begin
        out_byte_r <= src_r;
      end else if (emit_k_r == IW'(2)) begin
        out_byte_r <= BW'(frame_len_r);
      end else begin
        out_byte_r <= rd_data_r;
      end
      out_index_r   <= emit_k_r;
      out_verdict_r <= rfcaf_pkg::V_ACCEPT;
      out_last_r    <= stat.emit_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_index   = out_index_r;
  assign out_verdict = out_verdict_r;
  assign out_last    = out_last_r;

endmodule

`default_nettype wire
